### rtl/core/gri_pkg.sv
// Shared types, widths and codes for the gyro rate integrator.
`default_nettype none

package gri_pkg;

    // Field widths of the frame and result transactions.
    localparam int CH_W        = 2;
    localparam int PAY_W       = 24;
    localparam int TEMP_W      = 12;
    localparam int BIAS_W      = 24;
    localparam int RATE_W      = 27;
    localparam int CHG_W       = 28;
    localparam int ANGLE_OUT_W = 48;
    localparam int ANGLE_EXT_W = 64;
    localparam int AVG_W       = 27;
    localparam int WACC_W      = 44;
    localparam int CNT_W       = 16;
    localparam int RECIP_W     = 25;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int NUM_BIAS   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_CH0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_CH1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_CH2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RECIP = 3'd4;

    localparam logic [CNT_W-1:0]   WINDOW_LEN_RST   = 16'd1000;
    localparam logic [RECIP_W-1:0] WINDOW_RECIP_RST = 25'd16777;

    // Frame kinds.
    localparam logic KIND_RATE = 1'b0;
    localparam logic KIND_TEMP = 1'b1;

    // Rate scaling: raw count times RATE_SCALE, then an arithmetic shift.
    localparam int RATE_SCALE  = 239675;
    localparam int SCALE_SHIFT = 16;
    localparam int SCALED_W    = 26;

    // Shared multiplier and window average.
    localparam int MUL_A_W     = 24;
    localparam int MUL_B_W     = 26;
    localparam int MUL_P_W     = 50;
    localparam int SPLIT       = 22;
    localparam int LO_PROD_W   = 47;
    localparam int RECIP_SHIFT = 24;
    localparam int AVG_TOT_W   = 70;
    localparam int AVG_FULL_W  = AVG_TOT_W - RECIP_SHIFT;

    // Defaults of the top-level parameters.
    localparam int NUM_CHANNELS_DEF = 3;
    localparam int ANGLE_WIDTH_DEF  = 48;

    // Multiplier operand selection.
    localparam logic [1:0] MUL_SEL_SCALE = 2'd0;
    localparam logic [1:0] MUL_SEL_LO    = 2'd1;
    localparam logic [1:0] MUL_SEL_HI    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       hold_lo;
        logic       update;
        logic       avg_write;
        logic       load_out;
    } gri_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_closed;
    } gri_status_t;

endpackage

`default_nettype wire

### rtl/core/gri_ctrl.sv
// Controller state machine that sequences one frame through the datapath.
`default_nettype none

module gri_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire gri_pkg::gri_status_t status,
    output gri_pkg::gri_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCALE  = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_MUL_LO = 3'd3;
    localparam logic [2:0] ST_MUL_HI = 3'd4;
    localparam logic [2:0] ST_AVG    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    // The result register can be loaded when it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gri_pkg::MUL_SEL_SCALE;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.win_closed ? ST_MUL_LO : ST_FINISH;
            end
            ST_MUL_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gri_pkg::MUL_SEL_LO;
                state_next  = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gri_pkg::MUL_SEL_HI;
                cmd.hold_lo = 1'b1;
                state_next  = ST_AVG;
            end
            ST_AVG: begin
                cmd.avg_write = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag follows loads and downstream acceptance.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/gri_datapath.sv
// Datapath: configuration, per-channel state, shared multiplier and result register.
`default_nettype none

module gri_datapath #(
    parameter int NUM_CHANNELS = gri_pkg::NUM_CHANNELS_DEF,
    parameter int ANGLE_WIDTH  = gri_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire gri_pkg::gri_cmd_t                    cmd,
    output gri_pkg::gri_status_t                      status,
    input  wire logic                                 cfg_valid,
    input  wire logic [gri_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gri_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 s_func,
    input  wire logic [gri_pkg::CH_W-1:0]             s_channel,
    input  wire logic [gri_pkg::PAY_W-1:0]            s_frame_payload,
    output logic [gri_pkg::CH_W-1:0]                  m_out_channel,
    output logic                                      m_out_kind,
    output logic signed [gri_pkg::RATE_W-1:0]         m_rate_value,
    output logic signed [gri_pkg::CHG_W-1:0]          m_rate_change,
    output logic signed [gri_pkg::ANGLE_OUT_W-1:0]    m_angle_sum,
    output logic                                      m_avg_valid,
    output logic signed [gri_pkg::AVG_W-1:0]          m_avg_rate,
    output logic signed [gri_pkg::TEMP_W-1:0]         m_temperature,
    output logic signed [gri_pkg::TEMP_W-1:0]         m_temp_at_avg,
    output logic                                      m_round_done
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration registers.
    logic signed [gri_pkg::BIAS_W-1:0]  bias_reg [gri_pkg::NUM_BIAS];
    logic [gri_pkg::CNT_W-1:0]          win_len_reg;
    logic [gri_pkg::RECIP_W-1:0]        win_recip_reg;

    // Captured frame.
    logic                               kind_reg;
    logic [gri_pkg::CH_W-1:0]           chan_reg;
    logic [gri_pkg::PAY_W-1:0]          pay_reg;

    // Per-channel state.
    logic signed [gri_pkg::RATE_W-1:0]  last_rate_reg    [NUM_CHANNELS];
    logic [ANGLE_WIDTH-1:0]             angle_reg        [NUM_CHANNELS];
    logic signed [gri_pkg::WACC_W-1:0]  window_acc_reg   [NUM_CHANNELS];
    logic [gri_pkg::CNT_W-1:0]          window_count_reg [NUM_CHANNELS];
    logic signed [gri_pkg::AVG_W-1:0]   avg_hold_reg     [NUM_CHANNELS];
    logic signed [gri_pkg::TEMP_W-1:0]  temp_now_reg     [NUM_CHANNELS];
    logic signed [gri_pkg::TEMP_W-1:0]  temp_latched_reg [NUM_CHANNELS];

    // Working registers.
    logic signed [gri_pkg::MUL_P_W-1:0] prod_reg;
    logic [gri_pkg::LO_PROD_W-1:0]      lo_prod_reg;
    logic signed [gri_pkg::WACC_W-1:0]  avg_sum_reg;
    logic signed [gri_pkg::CHG_W-1:0]   change_reg;
    logic                               closed_reg;

    // Result register.
    logic [gri_pkg::CH_W-1:0]           out_channel_reg;
    logic                               out_kind_reg;
    logic signed [gri_pkg::RATE_W-1:0]  rate_value_reg;
    logic signed [gri_pkg::CHG_W-1:0]   rate_change_reg;
    logic [gri_pkg::ANGLE_OUT_W-1:0]    angle_sum_reg;
    logic                               avg_valid_reg;
    logic signed [gri_pkg::AVG_W-1:0]   avg_rate_reg;
    logic signed [gri_pkg::TEMP_W-1:0]  temperature_reg;
    logic signed [gri_pkg::TEMP_W-1:0]  temp_at_avg_reg;
    logic                               round_done_reg;

    // Combinational signals.
    logic                               chan_ok;
    logic [IDX_W-1:0]                   ch_idx;
    logic [gri_pkg::CH_W-1:0]           bias_idx;
    logic signed [gri_pkg::BIAS_W-1:0]  bias_sel;
    logic signed [gri_pkg::SCALED_W-1:0] scaled;
    logic signed [gri_pkg::RATE_W-1:0]  rate_calc;
    logic signed [gri_pkg::CHG_W-1:0]   change_calc;
    logic signed [gri_pkg::WACC_W-1:0]  wsum;
    logic [gri_pkg::CNT_W:0]            cnt_inc;
    logic                               win_closed;
    logic signed [gri_pkg::MUL_A_W-1:0] mul_a;
    logic signed [gri_pkg::MUL_B_W-1:0] mul_b;
    logic signed [gri_pkg::MUL_P_W-1:0] mul_p;
    logic signed [gri_pkg::SPLIT-1:0]   sum_hi;
    logic signed [gri_pkg::AVG_TOT_W-1:0] avg_total;
    logic signed [gri_pkg::AVG_FULL_W-1:0] avg_full;
    logic signed [gri_pkg::AVG_W-1:0]   avg_sat;
    logic [gri_pkg::ANGLE_EXT_W-1:0]    angle_ext;

    // Channel selection; out-of-range channels touch no state.
    assign chan_ok  = (chan_reg < gri_pkg::CH_W'(NUM_CHANNELS));
    assign ch_idx   = chan_ok ? chan_reg[IDX_W-1:0] : '0;
    assign bias_idx = chan_ok ? chan_reg : '0;
    assign bias_sel = bias_reg[bias_idx];

    // Rate path: floor of the scaled product, bias removed.
    assign scaled      = prod_reg[gri_pkg::SCALE_SHIFT +: gri_pkg::SCALED_W];
    assign rate_calc   = gri_pkg::RATE_W'(scaled) - gri_pkg::RATE_W'(bias_sel);
    assign change_calc = gri_pkg::CHG_W'(rate_calc) - gri_pkg::CHG_W'(last_rate_reg[ch_idx]);
    assign wsum        = window_acc_reg[ch_idx] + gri_pkg::WACC_W'(rate_calc);
    assign cnt_inc     = {1'b0, window_count_reg[ch_idx]} + 1'b1;
    assign win_closed  = chan_ok && (kind_reg == gri_pkg::KIND_RATE)
                         && (cnt_inc >= {1'b0, win_len_reg});

    assign status.win_closed = win_closed;

    // Shared multiplier operands: rate scaling, then the two halves of the
    // window sum times the reciprocal.
    assign sum_hi = avg_sum_reg[gri_pkg::WACC_W-1:gri_pkg::SPLIT];

    always_comb begin
        unique case (cmd.mul_sel)
            gri_pkg::MUL_SEL_SCALE: begin
                mul_a = pay_reg;
                mul_b = gri_pkg::MUL_B_W'(gri_pkg::RATE_SCALE);
            end
            gri_pkg::MUL_SEL_LO: begin
                mul_a = {{(gri_pkg::MUL_A_W - gri_pkg::SPLIT){1'b0}},
                         avg_sum_reg[gri_pkg::SPLIT-1:0]};
                mul_b = {1'b0, win_recip_reg};
            end
            gri_pkg::MUL_SEL_HI: begin
                mul_a = gri_pkg::MUL_A_W'(sum_hi);
                mul_b = {1'b0, win_recip_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Window average: high partial product shifted over the low one, then
    // the reciprocal scaling shift and saturation to the result range.
    assign avg_total = (gri_pkg::AVG_TOT_W'(prod_reg) <<< gri_pkg::SPLIT)
                       + gri_pkg::AVG_TOT_W'(lo_prod_reg);
    assign avg_full  = avg_total[gri_pkg::AVG_TOT_W-1:gri_pkg::RECIP_SHIFT];

    always_comb begin
        if (avg_full[gri_pkg::AVG_FULL_W-1:gri_pkg::AVG_W-1]
            == {(gri_pkg::AVG_FULL_W - gri_pkg::AVG_W + 1){avg_full[gri_pkg::AVG_FULL_W-1]}})
        begin
            avg_sat = avg_full[gri_pkg::AVG_W-1:0];
        end else if (avg_full[gri_pkg::AVG_FULL_W-1]) begin
            avg_sat = {1'b1, {(gri_pkg::AVG_W-1){1'b0}}};
        end else begin
            avg_sat = {1'b0, {(gri_pkg::AVG_W-1){1'b1}}};
        end
    end

    // Angle shown as a sign-extended value trimmed to the result field.
    assign angle_ext = gri_pkg::ANGLE_EXT_W'(signed'(angle_reg[ch_idx]));

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < gri_pkg::NUM_BIAS; i++) begin
                bias_reg[i] <= '0;
            end
            win_len_reg   <= gri_pkg::WINDOW_LEN_RST;
            win_recip_reg <= gri_pkg::WINDOW_RECIP_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gri_pkg::CFG_BIAS_CH0: bias_reg[0] <= cfg_data[gri_pkg::BIAS_W-1:0];
                gri_pkg::CFG_BIAS_CH1: bias_reg[1] <= cfg_data[gri_pkg::BIAS_W-1:0];
                gri_pkg::CFG_BIAS_CH2: bias_reg[2] <= cfg_data[gri_pkg::BIAS_W-1:0];
                gri_pkg::CFG_WINDOW_LEN: win_len_reg <= cfg_data[gri_pkg::CNT_W-1:0];
                gri_pkg::CFG_WINDOW_RECIP: win_recip_reg <= cfg_data[gri_pkg::RECIP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Frame capture and working registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_func;
            chan_reg <= s_channel;
            pay_reg  <= s_frame_payload;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.hold_lo) begin
            lo_prod_reg <= prod_reg[gri_pkg::LO_PROD_W-1:0];
        end
        if (cmd.update) begin
            avg_sum_reg <= wsum;
            closed_reg  <= win_closed;
            change_reg  <= (kind_reg == gri_pkg::KIND_RATE) ? change_calc : '0;
        end
    end

    // Per-channel state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                last_rate_reg[i]    <= '0;
                angle_reg[i]        <= '0;
                window_acc_reg[i]   <= '0;
                window_count_reg[i] <= '0;
                avg_hold_reg[i]     <= '0;
                temp_now_reg[i]     <= '0;
                temp_latched_reg[i] <= '0;
            end
        end else begin
            if (cmd.update && chan_ok) begin
                if (kind_reg == gri_pkg::KIND_RATE) begin
                    last_rate_reg[ch_idx] <= rate_calc;
                    angle_reg[ch_idx]     <= angle_reg[ch_idx] + ANGLE_WIDTH'(rate_calc);
                    if (win_closed) begin
                        window_acc_reg[ch_idx]   <= '0;
                        window_count_reg[ch_idx] <= '0;
                        temp_latched_reg[ch_idx] <= temp_now_reg[ch_idx];
                    end else begin
                        window_acc_reg[ch_idx]   <= wsum;
                        window_count_reg[ch_idx] <= cnt_inc[gri_pkg::CNT_W-1:0];
                    end
                end else begin
                    temp_now_reg[ch_idx] <= pay_reg[gri_pkg::PAY_W-1 -: gri_pkg::TEMP_W];
                end
            end
            if (cmd.avg_write && chan_ok) begin
                avg_hold_reg[ch_idx] <= avg_sat;
            end
        end
    end

    // Result register, loaded once the channel state is final.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_channel_reg <= chan_reg;
            out_kind_reg    <= kind_reg;
            if (chan_ok) begin
                rate_value_reg  <= last_rate_reg[ch_idx];
                rate_change_reg <= change_reg;
                angle_sum_reg   <= angle_ext[gri_pkg::ANGLE_OUT_W-1:0];
                avg_valid_reg   <= closed_reg;
                avg_rate_reg    <= avg_hold_reg[ch_idx];
                temperature_reg <= temp_now_reg[ch_idx];
                temp_at_avg_reg <= temp_latched_reg[ch_idx];
                round_done_reg  <= (kind_reg == gri_pkg::KIND_TEMP)
                                   && (chan_reg == gri_pkg::CH_W'(NUM_CHANNELS - 1));
            end else begin
                rate_value_reg  <= '0;
                rate_change_reg <= '0;
                angle_sum_reg   <= '0;
                avg_valid_reg   <= 1'b0;
                avg_rate_reg    <= '0;
                temperature_reg <= '0;
                temp_at_avg_reg <= '0;
                round_done_reg  <= 1'b0;
            end
        end
    end

    assign m_out_channel = out_channel_reg;
    assign m_out_kind    = out_kind_reg;
    assign m_rate_value  = rate_value_reg;
    assign m_rate_change = rate_change_reg;
    assign m_angle_sum   = angle_sum_reg;
    assign m_avg_valid   = avg_valid_reg;
    assign m_avg_rate    = avg_rate_reg;
    assign m_temperature = temperature_reg;
    assign m_temp_at_avg = temp_at_avg_reg;
    assign m_round_done  = round_done_reg;

endmodule

`default_nettype wire

### rtl/core/gyro_rate_integrator.sv
// Top level of the gyro rate integrator: controller plus datapath.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_func, s_channel, s_frame_payload
//  m_        out        m_valid / m_ready    m_out_channel .. m_round_done
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A frame runs through capture, scale multiply, state update and result load.
// A rate frame that closes a window also runs the window average: two more
// passes through the single 24x26 multiplier and one add-and-saturate step.
// Reset (aresetn low, synchronous) clears all channel state and returns the
// configuration registers to their defaults.
// A stalled result waits in the output register; the next frame is taken and
// processed meanwhile, and only its result load waits for the register to drain.
`default_nettype none

module gyro_rate_integrator #(
    parameter int NUM_CHANNELS = gri_pkg::NUM_CHANNELS_DEF,
    parameter int ANGLE_WIDTH  = gri_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_func,
    input  wire logic [gri_pkg::CH_W-1:0]             s_channel,
    input  wire logic [gri_pkg::PAY_W-1:0]            s_frame_payload,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [gri_pkg::CH_W-1:0]                  m_out_channel,
    output logic                                      m_out_kind,
    output logic signed [gri_pkg::RATE_W-1:0]         m_rate_value,
    output logic signed [gri_pkg::CHG_W-1:0]          m_rate_change,
    output logic signed [gri_pkg::ANGLE_OUT_W-1:0]    m_angle_sum,
    output logic                                      m_avg_valid,
    output logic signed [gri_pkg::AVG_W-1:0]          m_avg_rate,
    output logic signed [gri_pkg::TEMP_W-1:0]         m_temperature,
    output logic signed [gri_pkg::TEMP_W-1:0]         m_temp_at_avg,
    output logic                                      m_round_done,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [gri_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gri_pkg::CFG_DATA_W-1:0]       cfg_data
);

    gri_pkg::gri_cmd_t    cmd;
    gri_pkg::gri_status_t status;

    // Configuration writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;

    // Sequencer.
    gri_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, channel state and result register.
    gri_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ANGLE_WIDTH  (ANGLE_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_func          (s_func),
        .s_channel       (s_channel),
        .s_frame_payload (s_frame_payload),
        .m_out_channel   (m_out_channel),
        .m_out_kind      (m_out_kind),
        .m_rate_value    (m_rate_value),
        .m_rate_change   (m_rate_change),
        .m_angle_sum     (m_angle_sum),
        .m_avg_valid     (m_avg_valid),
        .m_avg_rate      (m_avg_rate),
        .m_temperature   (m_temperature),
        .m_temp_at_avg   (m_temp_at_avg),
        .m_round_done    (m_round_done)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the gyro rate integrator against a predictor.

module testbench;

    localparam int NUM_CH        = gri_pkg::NUM_CHANNELS_DEF;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_FRAMES  = 275;
    localparam int MAX_REPORTS   = 10;
    // Window-closing frames and random stalls are short; only the long receiver
    // hold-off goes long without a transaction, and it stays below this limit.
    localparam int QUIET_LIMIT   = 4000;

    localparam logic [gri_pkg::CH_W-1:0]  CH_ABSENT   = gri_pkg::CH_W'(NUM_CH);
    localparam logic [gri_pkg::PAY_W-1:0] RAW_MAX     = 24'h7FFFFF;
    localparam logic [gri_pkg::PAY_W-1:0] RAW_MIN     = 24'h800000;
    localparam logic [gri_pkg::PAY_W-1:0] RAW_NEG_ONE = 24'hFFFFFF;
    localparam longint RECIP_UNITY = longint'(1) <<< gri_pkg::RECIP_SHIFT;
    localparam longint RECIP_FULL  = (longint'(1) <<< gri_pkg::RECIP_W) - 1;
    localparam int unsigned WIN_LEN_MAX = (1 << gri_pkg::CNT_W) - 1;
    localparam longint AVG_MAX = (longint'(1) <<< (gri_pkg::AVG_W - 1)) - 1;
    localparam longint AVG_MIN = -(longint'(1) <<< (gri_pkg::AVG_W - 1));

    // One result transaction, field by field.
    typedef struct {
        logic [gri_pkg::CH_W-1:0]               channel;
        logic                                   kind;
        logic signed [gri_pkg::RATE_W-1:0]      rate;
        logic signed [gri_pkg::CHG_W-1:0]       change;
        logic signed [gri_pkg::ANGLE_OUT_W-1:0] angle;
        logic                                   avg_valid;
        logic signed [gri_pkg::AVG_W-1:0]       avg;
        logic signed [gri_pkg::TEMP_W-1:0]      temp;
        logic signed [gri_pkg::TEMP_W-1:0]      temp_avg;
        logic                                   round_done;
    } gyro_result_t;

    logic                                   aclk;
    logic                                   aresetn         = 1'b0;
    logic                                   s_valid         = 1'b0;
    logic                                   s_ready;
    logic                                   s_func          = gri_pkg::KIND_RATE;
    logic [gri_pkg::CH_W-1:0]               s_channel       = '0;
    logic [gri_pkg::PAY_W-1:0]              s_frame_payload = '0;
    logic                                   m_valid;
    logic                                   m_ready         = 1'b0;
    logic [gri_pkg::CH_W-1:0]               m_out_channel;
    logic                                   m_out_kind;
    logic signed [gri_pkg::RATE_W-1:0]      m_rate_value;
    logic signed [gri_pkg::CHG_W-1:0]       m_rate_change;
    logic signed [gri_pkg::ANGLE_OUT_W-1:0] m_angle_sum;
    logic                                   m_avg_valid;
    logic signed [gri_pkg::AVG_W-1:0]       m_avg_rate;
    logic signed [gri_pkg::TEMP_W-1:0]      m_temperature;
    logic signed [gri_pkg::TEMP_W-1:0]      m_temp_at_avg;
    logic                                   m_round_done;
    logic                                   cfg_valid       = 1'b0;
    logic                                   cfg_ready;
    logic [gri_pkg::CFG_IDX_W-1:0]          cfg_index       = '0;
    logic [gri_pkg::CFG_DATA_W-1:0]         cfg_data        = '0;

    // Predictor copy of the configuration registers.
    longint      bias_q16 [gri_pkg::NUM_BIAS] = '{default: 0};
    int unsigned win_len_cfg                  = gri_pkg::WINDOW_LEN_RST;
    longint      win_recip_cfg                = gri_pkg::WINDOW_RECIP_RST;

    // Predictor copy of the per-channel state.
    longint                              prev_rate_q16 [NUM_CH] = '{default: 0};
    logic [gri_pkg::ANGLE_WIDTH_DEF-1:0] angle_q16     [NUM_CH] = '{default: '0};
    longint                              win_sum       [NUM_CH] = '{default: 0};
    int unsigned                         win_cnt       [NUM_CH] = '{default: 0};
    longint                              avg_q16       [NUM_CH] = '{default: 0};
    logic signed [gri_pkg::TEMP_W-1:0]   temp_q4       [NUM_CH] = '{default: '0};
    logic signed [gri_pkg::TEMP_W-1:0]   temp_hold_q4  [NUM_CH] = '{default: '0};

    gyro_result_t pending_results [$];
    int unsigned  mismatch_count = 0;

    // Idling controls; the receiver owns its hold-off counter.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;

    gyro_rate_integrator dut (.*);

    // Free-running clock, 20 ns period.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Applies one frame to the predictor state and returns its result.
    function automatic gyro_result_t integrate_frame(logic kind,
                                                     logic [gri_pkg::CH_W-1:0] ch,
                                                     logic [gri_pkg::PAY_W-1:0] pay);
        gyro_result_t       res;
        longint             scaled;
        longint             rate_q16;
        longint             delta;
        logic signed [95:0] avg_wide;
        res = '{default: '0};
        res.channel = ch;
        res.kind    = kind;
        // A channel with no gyro behind it changes nothing and reports zeros.
        if (ch >= NUM_CH)
            return res;
        delta = 0;
        if (kind == gri_pkg::KIND_RATE) begin
            scaled   = (longint'($signed(pay)) * gri_pkg::RATE_SCALE)
                       >>> gri_pkg::SCALE_SHIFT;
            rate_q16 = scaled - bias_q16[ch];
            delta    = rate_q16 - prev_rate_q16[ch];
            prev_rate_q16[ch] = rate_q16;
            angle_q16[ch] = angle_q16[ch] + gri_pkg::ANGLE_WIDTH_DEF'(rate_q16);
            win_sum[ch] += rate_q16;
            // The window closes once the count reaches or passes its length.
            if (win_cnt[ch] + 1 >= win_len_cfg) begin
                avg_wide = win_sum[ch];
                avg_wide = (avg_wide * win_recip_cfg) >>> gri_pkg::RECIP_SHIFT;
                if (avg_wide > AVG_MAX)
                    avg_q16[ch] = AVG_MAX;
                else if (avg_wide < AVG_MIN)
                    avg_q16[ch] = AVG_MIN;
                else
                    avg_q16[ch] = longint'(avg_wide);
                win_sum[ch]      = 0;
                win_cnt[ch]      = 0;
                temp_hold_q4[ch] = temp_q4[ch];
                res.avg_valid    = 1'b1;
            end else begin
                win_cnt[ch] = win_cnt[ch] + 1;
            end
        end else begin
            temp_q4[ch] = $signed(pay[gri_pkg::PAY_W-1:gri_pkg::PAY_W-gri_pkg::TEMP_W]);
        end
        res.rate       = gri_pkg::RATE_W'(prev_rate_q16[ch]);
        res.change     = gri_pkg::CHG_W'(delta);
        res.angle      = gri_pkg::ANGLE_OUT_W'($signed(angle_q16[ch]));
        res.avg        = gri_pkg::AVG_W'(avg_q16[ch]);
        res.temp       = temp_q4[ch];
        res.temp_avg   = temp_hold_q4[ch];
        res.round_done = (kind == gri_pkg::KIND_TEMP) && (ch == NUM_CH - 1);
        return res;
    endfunction

    function automatic void report_error(string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want)
            report_error($sformatf("%s: expected %0d, got %0d", name, want, got));
    endfunction

    // Compares each accepted result transaction with the oldest prediction.
    always @(posedge aclk) begin : result_check
        gyro_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_error("result transaction with no frame outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("out_channel", want.channel,    m_out_channel);
                check_field("out_kind",    want.kind,       m_out_kind);
                check_field("rate_value",  want.rate,       m_rate_value);
                check_field("rate_change", want.change,     m_rate_change);
                check_field("angle_sum",   want.angle,      m_angle_sum);
                check_field("avg_valid",   want.avg_valid,  m_avg_valid);
                check_field("avg_rate",    want.avg,        m_avg_rate);
                check_field("temperature", want.temp,       m_temperature);
                check_field("temp_at_avg", want.temp_avg,   m_temp_at_avg);
                check_field("round_done",  want.round_done, m_round_done);
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_ready     <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Ends the run if no transaction on any channel happens for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one frame, after an optional idle gap, and waits for its acceptance.
    task automatic send_frame(input logic kind, input logic [gri_pkg::CH_W-1:0] ch,
                              input logic [gri_pkg::PAY_W-1:0] pay);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        pending_results.push_back(integrate_frame(kind, ch, pay));
        s_valid         <= 1'b1;
        s_func          <= kind;
        s_channel       <= ch;
        s_frame_payload <= pay;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_frame();
        logic                      kind;
        logic [gri_pkg::CH_W-1:0]  ch;
        logic [gri_pkg::PAY_W-1:0] pay;
        kind = ($urandom_range(99) < 18) ? gri_pkg::KIND_TEMP : gri_pkg::KIND_RATE;
        ch   = ($urandom_range(99) < 4) ? CH_ABSENT
                                         : gri_pkg::CH_W'($urandom_range(NUM_CH - 1));
        case ($urandom_range(5))
            0:       pay = $urandom_range(1) ? RAW_MAX : RAW_MIN;
            1:       pay = gri_pkg::PAY_W'($urandom_range(2000)) - gri_pkg::PAY_W'(1000);
            default: pay = gri_pkg::PAY_W'($urandom);
        endcase
        send_frame(kind, ch, pay);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write transaction; the predictor follows it.
    task automatic write_reg(input logic [gri_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gri_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            gri_pkg::CFG_BIAS_CH0, gri_pkg::CFG_BIAS_CH1, gri_pkg::CFG_BIAS_CH2:
                bias_q16[idx] = longint'($signed(data[gri_pkg::BIAS_W-1:0]));
            gri_pkg::CFG_WINDOW_LEN:   win_len_cfg   = data[gri_pkg::CNT_W-1:0];
            gri_pkg::CFG_WINDOW_RECIP: win_recip_cfg = data[gri_pkg::RECIP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_window(input int unsigned len, input longint recip);
        write_reg(gri_pkg::CFG_WINDOW_LEN, gri_pkg::CFG_DATA_W'(len));
        write_reg(gri_pkg::CFG_WINDOW_RECIP, gri_pkg::CFG_DATA_W'(recip));
    endtask

    task automatic randomize_config();
        int unsigned len;
        for (int b = 0; b < gri_pkg::NUM_BIAS; b++)
            write_reg(gri_pkg::CFG_IDX_W'(gri_pkg::CFG_BIAS_CH0 + b),
                      gri_pkg::CFG_DATA_W'($urandom));
        len = $urandom_range(1, 24);
        if ($urandom_range(3) == 0)
            set_window(len, longint'($urandom_range(RECIP_FULL)));
        else
            set_window(len, RECIP_UNITY / len);
    endtask

    // Field extremes, temperature frames and the absent channel at reset settings.
    task automatic test_directed_frames();
        send_frame(gri_pkg::KIND_RATE, 0, '0);
        send_frame(gri_pkg::KIND_RATE, 0, RAW_MAX);
        send_frame(gri_pkg::KIND_RATE, 0, RAW_MIN);
        send_frame(gri_pkg::KIND_RATE, 1, RAW_NEG_ONE);
        send_frame(gri_pkg::KIND_RATE, 2, 24'h000001);
        // Hottest and coldest readings; the low 12 bits carry nothing.
        send_frame(gri_pkg::KIND_TEMP, 0, 24'h7FF000);
        send_frame(gri_pkg::KIND_TEMP, 1, 24'h800FFF);
        // A temperature frame of the last channel ends a polling round.
        send_frame(gri_pkg::KIND_TEMP, 2, RAW_NEG_ONE);
        send_frame(gri_pkg::KIND_RATE, CH_ABSENT, 24'h5A5A5A);
        send_frame(gri_pkg::KIND_TEMP, CH_ABSENT, RAW_NEG_ONE);
    endtask

    // Bias and window-length extremes, average saturation and spare indexes.
    task automatic test_window_edges();
        wait_idle();
        write_reg(gri_pkg::CFG_BIAS_CH0, gri_pkg::CFG_DATA_W'(RAW_MAX));
        write_reg(gri_pkg::CFG_BIAS_CH1, {1'b1, RAW_MIN});
        write_reg(gri_pkg::CFG_BIAS_CH2, '0);
        // A zero length closes a window on every sample.
        set_window(0, RECIP_FULL);
        send_frame(gri_pkg::KIND_RATE, 0, RAW_MIN);
        send_frame(gri_pkg::KIND_RATE, 1, RAW_MAX);
        send_frame(gri_pkg::KIND_RATE, 2, '0);
        send_frame(gri_pkg::KIND_TEMP, 0, 24'h7FF000);
        send_frame(gri_pkg::KIND_RATE, 0, RAW_MAX);
        wait_idle();

        // Three full-scale samples push the average past both rails.
        write_reg(gri_pkg::CFG_BIAS_CH0, '0);
        write_reg(gri_pkg::CFG_BIAS_CH1, '0);
        set_window(3, RECIP_UNITY);
        repeat (3) send_frame(gri_pkg::KIND_RATE, 2, RAW_MAX);
        repeat (3) send_frame(gri_pkg::KIND_RATE, 1, RAW_MIN);
        wait_idle();

        set_window(1, 0);
        send_frame(gri_pkg::KIND_RATE, 0, gri_pkg::PAY_W'($urandom));
        wait_idle();

        set_window(WIN_LEN_MAX, 256);
        send_frame(gri_pkg::KIND_RATE, 1, RAW_MAX);
        send_frame(gri_pkg::KIND_RATE, 2, RAW_MIN);
        wait_idle();

        // Writes to unassigned indexes must leave the settings alone.
        for (int idx = gri_pkg::CFG_WINDOW_RECIP + 1; idx < (1 << gri_pkg::CFG_IDX_W); idx++)
            write_reg(gri_pkg::CFG_IDX_W'(idx), gri_pkg::CFG_DATA_W'($urandom));
        send_frame(gri_pkg::KIND_RATE, 0, gri_pkg::PAY_W'($urandom));
    endtask

    // Random frames under each sender and receiver idling pattern.
    task automatic test_idle_phases();
        int unsigned send_pcts  [4] = '{0, 45, 0, 24};
        int unsigned stall_pcts [4] = '{0, 0, 45, 24};
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            randomize_config();
            send_idle_pct = send_pcts[p];
            stall_pct    <= stall_pcts[p];
            repeat (PHASE_FRAMES) send_random_frame();
        end
    endtask

    // Receiver holds off while frames keep coming, so the input stalls.
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        stall_pct     <= 0;
        hold_requests <= hold_requests + 1;
        repeat (40) send_random_frame();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frames();
        test_window_edges();
        test_idle_phases();
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
